// File: rtl/axis_reduction_engine_defines.svh
// Assertion helpers shared by the reduction engine RTL.
`ifndef AXIS_REDUCTION_ENGINE_DEFINES_SVH
`define AXIS_REDUCTION_ENGINE_DEFINES_SVH

// Condition must never hold outside reset.
`define ARE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ARE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ARE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/are_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package are_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int INNER_MAX_DEF  = 1024;
  localparam int AXIS_MAX_DEF   = 65536;

  localparam int ELEM_W     = 32;
  localparam int POS_W      = 10;
  localparam int OP_W       = 3;
  localparam int ALEN_W     = 17;
  localparam int ILEN_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [OP_W-1:0] OP_MAX    = 3'd0;
  localparam logic [OP_W-1:0] OP_MIN    = 3'd1;
  localparam logic [OP_W-1:0] OP_ARGMAX = 3'd2;
  localparam logic [OP_W-1:0] OP_ARGMIN = 3'd3;
  localparam logic [OP_W-1:0] OP_SUM    = 3'd4;
  localparam logic [OP_W-1:0] OP_MEAN   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_OP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ALEN_W-1:0] alen;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } div_stat_t;

  function automatic int acc_bits(int dw);
    return (dw + 16 > 64) ? 64 : dw + 16;
  endfunction

  function automatic int idx_bits(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Keep the low dw bits of a value, then the low 32 of those.
  function automatic logic [ELEM_W-1:0] out_word(logic [63:0] v, int dw);
    logic [63:0] m;
    logic [63:0] t;
    m = (dw >= 64) ? {64{1'b1}} : ((64'd1 << dw) - 64'd1);
    t = v & m;
    return t[ELEM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/are_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface are_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [are_pkg::ELEM_W-1:0]   element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

`default_nettype wire

// File: rtl/are_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface are_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [are_pkg::ELEM_W-1:0] reduced;
  logic [are_pkg::POS_W-1:0]         position;

  modport source (output valid, output reduced, output position, input ready);
  modport sink   (input valid, input reduced, input position, output ready);
endinterface

`default_nettype wire

// File: rtl/are_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module are_seq #(
  parameter int INNER_MAX = are_pkg::INNER_MAX_DEF,
  parameter int AXIS_MAX  = are_pkg::AXIS_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [are_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [are_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               accept,
  output are_pkg::cfg_t                      cfg,
  output logic [are_pkg::idx_bits(INNER_MAX)-1:0] slot,
  output logic [are_pkg::idx_bits(AXIS_MAX)-1:0]  axis,
  output logic                               first,
  output logic                               last
);

  localparam int IW = are_pkg::idx_bits(INNER_MAX);
  localparam int AW = are_pkg::idx_bits(AXIS_MAX);

  logic [are_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [are_pkg::ALEN_W-1:0] alen_r, alen_nxt;
  logic [are_pkg::ILEN_W-1:0] ilen_r, ilen_nxt;
  logic [IW-1:0]              inner_r, inner_nxt;
  logic [AW-1:0]              axis_r, axis_nxt;

  logic [are_pkg::ALEN_W-1:0] alen_in, alen_eff;
  logic [are_pkg::ILEN_W-1:0] ilen_in, ilen_eff;
  logic                       reg_hit;
  logic                       inner_wrap;

  assign alen_in = cfg_wdata[are_pkg::ALEN_W-1:0];
  assign ilen_in = cfg_wdata[are_pkg::ILEN_W-1:0];

  // Clamp lengths at write time: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (alen_in == '0) begin
      alen_eff = are_pkg::ALEN_W'(1);
    end else if (32'(alen_in) > 32'(AXIS_MAX)) begin
      alen_eff = are_pkg::ALEN_W'(AXIS_MAX);
    end else begin
      alen_eff = alen_in;
    end
    if (ilen_in == '0) begin
      ilen_eff = are_pkg::ILEN_W'(1);
    end else if (32'(ilen_in) > 32'(INNER_MAX)) begin
      ilen_eff = are_pkg::ILEN_W'(INNER_MAX);
    end else begin
      ilen_eff = ilen_in;
    end
  end

  assign last       = (32'(axis_r) + 32'd1 == 32'(alen_r));
  assign inner_wrap = (32'(inner_r) + 32'd1 == 32'(ilen_r));

  always_comb begin
    op_nxt    = op_r;
    alen_nxt  = alen_r;
    ilen_nxt  = ilen_r;
    inner_nxt = inner_r;
    axis_nxt  = axis_r;
    reg_hit   = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        are_pkg::REG_OP: begin
          op_nxt  = cfg_wdata[are_pkg::OP_W-1:0];
          reg_hit = 1'b1;
        end
        are_pkg::REG_AXIS: begin
          alen_nxt = alen_eff;
          reg_hit  = 1'b1;
        end
        are_pkg::REG_INNER: begin
          ilen_nxt = ilen_eff;
          reg_hit  = 1'b1;
        end
        default: reg_hit = 1'b0;
      endcase
    end
    if (reg_hit) begin
      // restart the tensor
      inner_nxt = '0;
      axis_nxt  = '0;
    end else if (accept) begin
      if (inner_wrap) begin
        inner_nxt = '0;
        axis_nxt  = last ? '0 : axis_r + AW'(1);
      end else begin
        inner_nxt = inner_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= are_pkg::OP_MAX;
      alen_r  <= are_pkg::ALEN_W'(1);
      ilen_r  <= are_pkg::ILEN_W'(1);
      inner_r <= '0;
      axis_r  <= '0;
    end else begin
      op_r    <= op_nxt;
      alen_r  <= alen_nxt;
      ilen_r  <= ilen_nxt;
      inner_r <= inner_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign cfg.op   = op_r;
  assign cfg.alen = alen_r;
  assign slot     = inner_r;
  assign axis     = axis_r;
  assign first    = (axis_r == '0);

endmodule

`default_nettype wire

// File: rtl/are_rmw.sv
`timescale 1ns / 1ps
`default_nettype none

module are_rmw #(
  parameter int DATA_WIDTH = are_pkg::DATA_WIDTH_DEF,
  parameter int INNER_MAX  = are_pkg::INNER_MAX_DEF,
  parameter int AXIS_MAX   = are_pkg::AXIS_MAX_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic signed [are_pkg::ELEM_W-1:0]       in_element,
  output logic                                    in_ready,
  output logic                                    accept,
  input  are_pkg::cfg_t                           cfg,
  input  logic [are_pkg::idx_bits(INNER_MAX)-1:0] slot,
  input  logic [are_pkg::idx_bits(AXIS_MAX)-1:0]  axis,
  input  logic                                    first,
  input  logic                                    last,
  input  logic                                    res_free,
  output logic                                    direct_valid,
  output logic [are_pkg::ELEM_W-1:0]              direct_value,
  output logic [are_pkg::POS_W-1:0]               res_pos,
  output logic                                    div_start,
  output logic signed [are_pkg::acc_bits(DATA_WIDTH)-1:0] div_dividend
);

  localparam int ACC_W = are_pkg::acc_bits(DATA_WIDTH);
  localparam int IW    = are_pkg::idx_bits(INNER_MAX);
  localparam int AW    = are_pkg::idx_bits(AXIS_MAX);
  localparam int EW    = ACC_W + AW;

  logic [EW-1:0] mem [INNER_MAX];

  logic [EW-1:0]           rd_data_r;
  logic                    fwd_r, fwd_nxt;
  logic [EW-1:0]           fwd_data_r;
  logic                    s1_valid_r, s1_valid_nxt;
  logic [IW-1:0]           s1_slot_r;
  logic [AW-1:0]           s1_axis_r;
  logic                    s1_first_r;
  logic                    s1_last_r;
  logic signed [ACC_W-1:0] s1_elem_r;

  logic [63:0]             elem_wide;
  logic [DATA_WIDTH-1:0]   elem_dw;
  logic signed [ACC_W-1:0] elem_acc;

  logic                    s1_go;
  logic [EW-1:0]           entry;
  logic signed [ACC_W-1:0] best;
  logic [AW-1:0]           best_idx;
  logic signed [ACC_W-1:0] new_acc;
  logic [AW-1:0]           new_idx;
  logic [EW-1:0]           wr_data;
  logic [31:0]             slot_wide;

  // Element as a DATA_WIDTH-bit two's complement value, widened for the store.
  assign elem_wide = {32'd0, in_element};
  assign elem_dw   = elem_wide[DATA_WIDTH-1:0];
  assign elem_acc  = ACC_W'($signed(elem_dw));

  assign s1_go    = s1_valid_r && (!s1_last_r || res_free);
  assign in_ready = !s1_valid_r || s1_go;
  assign accept   = in_valid && in_ready;

  // Take the entry just written when the next transaction hits the same slot.
  assign entry    = fwd_r ? fwd_data_r : rd_data_r;
  assign best     = entry[EW-1:AW];
  assign best_idx = entry[AW-1:0];

  always_comb begin
    new_acc = best;
    new_idx = best_idx;
    if (s1_first_r) begin
      new_acc = s1_elem_r;
      new_idx = '0;
    end else begin
      case (cfg.op)
        are_pkg::OP_MAX, are_pkg::OP_ARGMAX: begin
          if (s1_elem_r > best) begin
            new_acc = s1_elem_r;
            new_idx = s1_axis_r;
          end
        end
        are_pkg::OP_MIN, are_pkg::OP_ARGMIN: begin
          if (s1_elem_r < best) begin
            new_acc = s1_elem_r;
            new_idx = s1_axis_r;
          end
        end
        are_pkg::OP_SUM, are_pkg::OP_MEAN: begin
          new_acc = best + s1_elem_r;
        end
        default: begin
          new_acc = best;
          new_idx = best_idx;
        end
      endcase
    end
  end

  assign wr_data = {new_acc, new_idx};

  always_comb begin
    case (cfg.op)
      are_pkg::OP_MAX, are_pkg::OP_MIN, are_pkg::OP_SUM:
        direct_value = are_pkg::out_word(64'(new_acc), DATA_WIDTH);
      are_pkg::OP_ARGMAX, are_pkg::OP_ARGMIN:
        direct_value = are_pkg::ELEM_W'(new_idx);
      default:
        direct_value = '0;
    endcase
  end

  assign direct_valid = s1_go && s1_last_r && (cfg.op != are_pkg::OP_MEAN);
  assign div_start    = s1_go && s1_last_r && (cfg.op == are_pkg::OP_MEAN);
  assign div_dividend = new_acc;
  assign slot_wide    = 32'(s1_slot_r);
  assign res_pos      = slot_wide[are_pkg::POS_W-1:0];

  assign fwd_nxt      = s1_go && (s1_slot_r == slot);
  assign s1_valid_nxt = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (s1_go) begin
      mem[s1_slot_r] <= wr_data;
    end
    if (accept) begin
      rd_data_r <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_r      <= fwd_nxt;
      fwd_data_r <= wr_data;
      s1_slot_r  <= slot;
      s1_axis_r  <= axis;
      s1_first_r <= first;
      s1_last_r  <= last;
      s1_elem_r  <= elem_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/are_div.sv
`timescale 1ns / 1ps
`default_nettype none

module are_div #(
  parameter int DATA_WIDTH = are_pkg::DATA_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            start,
  input  logic signed [are_pkg::acc_bits(DATA_WIDTH)-1:0] dividend,
  input  logic [are_pkg::ALEN_W-1:0]                      divisor,
  input  logic [are_pkg::POS_W-1:0]                       tag_in,
  input  logic                                            res_ready,
  output are_pkg::div_stat_t                              stat,
  output logic signed [are_pkg::acc_bits(DATA_WIDTH)-1:0] quot,
  output logic [are_pkg::POS_W-1:0]                       tag_out
);

  localparam int ACC_W = are_pkg::acc_bits(DATA_WIDTH);
  localparam int CW    = $clog2(ACC_W);
  localparam int DW    = are_pkg::ALEN_W;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  div_state_t          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [ACC_W-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]       rem_r, rem_nxt;
  logic [DW-1:0]       dvs_r, dvs_nxt;
  logic                neg_r, neg_nxt;
  logic [are_pkg::POS_W-1:0] tag_r, tag_nxt;

  logic [DW:0]         shifted;
  logic [DW:0]         diff;
  logic                ge;

  // Restoring division, one quotient bit per cycle on the magnitude.
  assign shifted = {rem_r, quo_r[ACC_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    tag_nxt   = tag_r;
    case (state_r)
      DIV_IDLE: begin
        if (start) begin
          neg_nxt   = dividend[ACC_W-1];
          quo_nxt   = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
          rem_nxt   = '0;
          dvs_nxt   = divisor;
          tag_nxt   = tag_in;
          cnt_nxt   = '0;
          state_nxt = DIV_RUN;
        end
      end
      DIV_RUN: begin
        quo_nxt = {quo_r[ACC_W-2:0], ge};
        rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(ACC_W - 1)) begin
          state_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (res_ready) begin
          state_nxt = DIV_IDLE;
        end
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    tag_r <= tag_nxt;
  end

  // Truncation toward zero: negate the magnitude quotient for a negative sum.
  assign quot           = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign tag_out        = tag_r;
  assign stat.idle      = (state_r == DIV_IDLE);
  assign stat.res_valid = (state_r == DIV_DONE);

endmodule

`default_nettype wire

// File: rtl/axis_reduction_engine.sv
// Axis reduction engine: max, min, argmax, argmin, sum and mean along one tensor axis.
// Throughput: one element per cycle, set by one store read-modify-write per element,
// except that a last element waits for an idle divider and a free output register.
// Each result is staged, then loaded into the output register; a mean passes the divider.
// Reset (synchronous, rst_n low): registers back to max, axis and inner length one,
// counters cleared; store contents stay undefined and are rewritten at axis position zero.
`timescale 1ns / 1ps
`default_nettype none
`include "axis_reduction_engine_defines.svh"

module axis_reduction_engine #(
  parameter int DATA_WIDTH = are_pkg::DATA_WIDTH_DEF,
  parameter int INNER_MAX  = are_pkg::INNER_MAX_DEF,
  parameter int AXIS_MAX   = are_pkg::AXIS_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  are_in_if.sink                         in_ch,
  are_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [are_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [are_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ACC_W = are_pkg::acc_bits(DATA_WIDTH);
  localparam int IW    = are_pkg::idx_bits(INNER_MAX);
  localparam int AW    = are_pkg::idx_bits(AXIS_MAX);

  are_pkg::cfg_t             cfg;
  are_pkg::div_stat_t        div_stat;
  logic [IW-1:0]             slot;
  logic [AW-1:0]             axis;
  logic                      first;
  logic                      last;
  logic                      accept;
  logic                      res_free;
  logic                      direct_valid;
  logic [are_pkg::ELEM_W-1:0] direct_value;
  logic [are_pkg::POS_W-1:0] res_pos;
  logic                      div_start;
  logic signed [ACC_W-1:0]   div_dividend;
  logic signed [ACC_W-1:0]   div_quot;
  logic [are_pkg::POS_W-1:0] div_tag;
  logic                      div_res_ready;
  logic                      div_load;
  logic                      div_wait;

  logic                       out_valid_r, out_valid_nxt;
  logic [are_pkg::ELEM_W-1:0] reduced_r, reduced_nxt;
  logic [are_pkg::POS_W-1:0]  position_r, position_nxt;

  are_seq #(
    .INNER_MAX (INNER_MAX),
    .AXIS_MAX  (AXIS_MAX)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .cfg       (cfg),
    .slot      (slot),
    .axis      (axis),
    .first     (first),
    .last      (last)
  );

  are_rmw #(
    .DATA_WIDTH (DATA_WIDTH),
    .INNER_MAX  (INNER_MAX),
    .AXIS_MAX   (AXIS_MAX)
  ) u_rmw (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_element   (in_ch.element),
    .in_ready     (in_ch.ready),
    .accept       (accept),
    .cfg          (cfg),
    .slot         (slot),
    .axis         (axis),
    .first        (first),
    .last         (last),
    .res_free     (res_free),
    .direct_valid (direct_valid),
    .direct_value (direct_value),
    .res_pos      (res_pos),
    .div_start    (div_start),
    .div_dividend (div_dividend)
  );

  are_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (cfg.alen),
    .tag_in    (res_pos),
    .res_ready (div_res_ready),
    .stat      (div_stat),
    .quot      (div_quot),
    .tag_out   (div_tag)
  );

  // Output register frees when empty or drained in the same cycle.
  assign div_res_ready = !out_valid_r || out_ch.ready;
  assign res_free      = div_stat.idle && div_res_ready;
  assign div_load      = div_stat.res_valid && div_res_ready;
  assign div_wait      = div_stat.res_valid && !div_res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    reduced_nxt   = reduced_r;
    position_nxt  = position_r;
    if (direct_valid) begin
      out_valid_nxt = 1'b1;
      reduced_nxt   = direct_value;
      position_nxt  = res_pos;
    end else if (div_load) begin
      out_valid_nxt = 1'b1;
      reduced_nxt   = are_pkg::out_word(64'(div_quot), DATA_WIDTH);
      position_nxt  = div_tag;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reduced_r  <= reduced_nxt;
    position_r <= position_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.reduced  = reduced_r;
  assign out_ch.position = position_r;

  `ARE_ASSERT_NEVER(a_one_src, clk, rst_n, direct_valid && div_stat.res_valid, "two sources")
  `ARE_ASSERT_IMP(a_div_idle, clk, rst_n, div_start, div_stat.idle, "divider started while busy")
  `ARE_ASSERT_NEXT(a_div_hold, clk, rst_n, div_wait, div_stat.res_valid, "quotient lost")

endmodule

`default_nettype wire

// File: sim/tb_axis_reduction_engine.sv
`timescale 1ns / 1ps

module tb_axis_reduction_engine;

  // Codes with no package name: spare operations and the unmapped register slot.
  localparam logic [are_pkg::OP_W-1:0]      OP_SPARE6 = 3'd6;
  localparam logic [are_pkg::OP_W-1:0]      OP_SPARE7 = 3'd7;
  localparam logic [are_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [are_pkg::ELEM_W-1:0] ELEM_TOP    = 32'sh7FFF_FFFF;
  localparam logic signed [are_pkg::ELEM_W-1:0] ELEM_BOTTOM = 32'sh8000_0000;

  // Result latency plus the worst-case mean divider pass, with margin.
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 750;
  localparam int CLAMP_ITEMS   = 64;
  localparam int JUNK_W        = are_pkg::CFG_DATA_W - are_pkg::ILEN_W;

  typedef struct packed {
    logic signed [are_pkg::ELEM_W-1:0] reduced;
    logic [are_pkg::POS_W-1:0]         position;
  } reduction_t;

  class reduction_scoreboard;
    logic [are_pkg::OP_W-1:0]     op;
    logic [are_pkg::ALEN_W-1:0]   axis_reg;
    logic [are_pkg::ILEN_W-1:0]   inner_reg;
    int unsigned                  inner_at;
    int unsigned                  axis_at;
    logic signed [47:0]           acc_mem [are_pkg::INNER_MAX_DEF];
    logic [15:0]                  idx_mem [are_pkg::INNER_MAX_DEF];
    reduction_t                   pending_results [$];
    int                           errors;

    function new();
      op        = are_pkg::OP_MAX;
      axis_reg  = 1;
      inner_reg = 1;
      inner_at  = 0;
      axis_at   = 0;
      errors    = 0;
    endfunction

    function int unsigned eff_axis();
      if (axis_reg == 0) return 1;
      if (axis_reg > are_pkg::AXIS_MAX_DEF) return are_pkg::AXIS_MAX_DEF;
      return axis_reg;
    endfunction

    function int unsigned eff_inner();
      if (inner_reg == 0) return 1;
      if (inner_reg > are_pkg::INNER_MAX_DEF) return are_pkg::INNER_MAX_DEF;
      return inner_reg;
    endfunction

    function void apply_config(logic [are_pkg::CFG_IDX_W-1:0] idx,
                               logic [are_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        are_pkg::REG_OP:    op = val[are_pkg::OP_W-1:0];
        are_pkg::REG_AXIS:  axis_reg = val[are_pkg::ALEN_W-1:0];
        are_pkg::REG_INNER: inner_reg = val[are_pkg::ILEN_W-1:0];
        default:            return;
      endcase
      // Any real register write restarts the tensor.
      inner_at = 0;
      axis_at  = 0;
    endfunction

    function void note_element(logic signed [are_pkg::ELEM_W-1:0] e);
      int unsigned        alen;
      int unsigned        ilen;
      int unsigned        slot;
      logic signed [47:0] wide;
      logic signed [47:0] cur;
      longint             quot;
      bit                 last;
      reduction_t         res;
      alen = eff_axis();
      ilen = eff_inner();
      if (inner_at >= ilen) inner_at = 0;
      if (axis_at >= alen) axis_at = 0;
      slot = inner_at % are_pkg::INNER_MAX_DEF;
      wide = e;
      if (axis_at == 0) begin
        acc_mem[slot] = wide;
        idx_mem[slot] = 16'd0;
      end else begin
        cur = acc_mem[slot];
        case (op)
          are_pkg::OP_MAX, are_pkg::OP_ARGMAX: begin
            if (wide > cur) begin
              acc_mem[slot] = wide;
              idx_mem[slot] = 16'(axis_at);
            end
          end
          are_pkg::OP_MIN, are_pkg::OP_ARGMIN: begin
            if (wide < cur) begin
              acc_mem[slot] = wide;
              idx_mem[slot] = 16'(axis_at);
            end
          end
          are_pkg::OP_SUM, are_pkg::OP_MEAN: acc_mem[slot] = cur + wide;
          default: ;
        endcase
      end
      last = (axis_at + 1 >= alen);
      if (last) begin
        case (op)
          are_pkg::OP_MAX, are_pkg::OP_MIN, are_pkg::OP_SUM:
            res.reduced = acc_mem[slot][are_pkg::ELEM_W-1:0];
          are_pkg::OP_ARGMAX, are_pkg::OP_ARGMIN:
            res.reduced = {16'd0, idx_mem[slot]};
          are_pkg::OP_MEAN: begin
            // Divide the exact wide sum, truncating toward zero.
            quot = longint'(acc_mem[slot]) / longint'(alen);
            res.reduced = quot[are_pkg::ELEM_W-1:0];
          end
          default: res.reduced = '0;
        endcase
        res.position = are_pkg::POS_W'(inner_at);
        pending_results.insert(pending_results.size(), res);
      end
      inner_at++;
      if (inner_at >= ilen) begin
        inner_at = 0;
        axis_at  = last ? 0 : axis_at + 1;
      end
    endfunction

    function void check_result(logic signed [are_pkg::ELEM_W-1:0] r,
                               logic [are_pkg::POS_W-1:0] p);
      reduction_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got reduced %0d position %0d",
                 $time, r, p);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (r !== want.reduced) begin
        $display("%0t: reduced mismatch: expected %0d, got %0d (position %0d)",
                 $time, want.reduced, r, want.position);
        errors++;
      end
      if (p !== want.position) begin
        $display("%0t: position mismatch: expected %0d, got %0d",
                 $time, want.position, p);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void report_missing();
      $display("%0t: missing results: expected %0d more, got 0",
               $time, pending_results.size());
      errors += pending_results.size();
      pending_results.delete();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [are_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [are_pkg::CFG_DATA_W-1:0] cfg_wdata;

  are_in_if  in_ch();
  are_out_if out_ch();

  reduction_scoreboard sb = new();

  bit feed_idle;
  bit drain_idle;
  bit hold_req;
  int random_sent;

  axis_reduction_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin : watchdog
    #10_000_000;
    $display("tb_axis_reduction_engine: FAIL");
    $finish;
  end

  // Result side: check each transaction, then stall at random while drain_idle is set, or on a hold request.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    @(negedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      stall = 0;
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.reduced, out_ch.position);
        stall = drain_idle ? $urandom_range(0, 9) : 0;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 300;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [are_pkg::ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 3))
      0: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
      1: begin
        case ($urandom_range(0, 5))
          0: return ELEM_TOP;
          1: return ELEM_BOTTOM;
          2: return ELEM_TOP - 1;
          3: return ELEM_BOTTOM + 1;
          4: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_element(input logic signed [are_pkg::ELEM_W-1:0] e);
    int gap;
    gap = feed_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.element <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_element(e);
  endtask

  task automatic write_reg(input logic [are_pkg::CFG_IDX_W-1:0] idx,
                           input logic [are_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.apply_config(idx, val);
  endtask

  // Drop valid, wait for every expected result, then let the divider go quiet.
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.outstanding() != 0) sb.report_missing();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_pair(input logic [are_pkg::OP_W-1:0] op,
                          input logic signed [are_pkg::ELEM_W-1:0] a,
                          input logic signed [are_pkg::ELEM_W-1:0] b);
    settle();
    write_reg(are_pkg::REG_OP, are_pkg::CFG_DATA_W'(op));
    send_element(a);
    send_element(b);
  endtask

  task automatic random_phase();
    logic [are_pkg::OP_W-1:0]       op_pick;
    logic [are_pkg::CFG_DATA_W-1:0] axis_pick;
    logic [are_pkg::CFG_DATA_W-1:0] inner_pick;
    int unsigned                    tensor;
    int unsigned                    count;
    settle();
    if ($urandom_range(0, 9) == 0) begin
      op_pick = ($urandom_range(0, 1) == 0) ? OP_SPARE6 : OP_SPARE7;
    end else begin
      op_pick = are_pkg::OP_W'($urandom_range(int'(are_pkg::OP_MAX), int'(are_pkg::OP_MEAN)));
    end
    case ($urandom_range(0, 15))
      0:       axis_pick = '0;
      1:       axis_pick = are_pkg::CFG_DATA_W'($urandom_range(9, 64));
      2:       axis_pick = are_pkg::CFG_DATA_W'($urandom_range(65537, 131071));
      default: axis_pick = are_pkg::CFG_DATA_W'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 9))
      0:       inner_pick = '0;
      1:       inner_pick = are_pkg::CFG_DATA_W'($urandom_range(9, 40));
      default: inner_pick = are_pkg::CFG_DATA_W'($urandom_range(1, 8));
    endcase
    // Junk in the bits above the inner length field must be ignored.
    if ($urandom_range(0, 3) == 0) begin
      inner_pick[are_pkg::CFG_DATA_W-1:are_pkg::ILEN_W] = JUNK_W'($urandom);
    end
    if ($urandom_range(0, 19) == 0) write_reg(REG_SPARE, are_pkg::CFG_DATA_W'($urandom));
    if ($urandom_range(0, 3) != 0) write_reg(are_pkg::REG_OP, are_pkg::CFG_DATA_W'(op_pick));
    if ($urandom_range(0, 3) != 0) write_reg(are_pkg::REG_AXIS, axis_pick);
    if ($urandom_range(0, 3) != 0) write_reg(are_pkg::REG_INNER, inner_pick);
    feed_idle  = ($urandom_range(0, 3) != 0);
    drain_idle = ($urandom_range(0, 3) != 0);
    tensor = sb.eff_axis() * sb.eff_inner();
    if (tensor <= 128) begin
      count = tensor * $urandom_range(1, 3);
      // Leave a broken tensor behind now and then.
      if ($urandom_range(0, 7) == 0) count += $urandom_range(1, tensor);
    end else begin
      count = $urandom_range(1, 60);
    end
    repeat (count) begin
      send_element(pick_element());
      random_sent++;
    end
  endtask

  initial begin : stimulus
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.element <= '0;
    feed_idle  = 1'b1;
    drain_idle = 1'b1;
    hold_req   = 1'b0;
    random_sent = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: max over an axis of one, so every element comes back.
    send_element(ELEM_TOP);
    send_element(ELEM_BOTTOM);

    settle();
    write_reg(are_pkg::REG_AXIS, 17'd2);
    write_reg(are_pkg::REG_INNER, 17'd1);
    run_pair(are_pkg::OP_MAX, ELEM_BOTTOM, ELEM_TOP);
    run_pair(are_pkg::OP_MIN, ELEM_TOP, ELEM_BOTTOM);
    run_pair(are_pkg::OP_ARGMAX, 32'sd5, 32'sd5);
    run_pair(are_pkg::OP_ARGMIN, -32'sd3, -32'sd3);
    run_pair(are_pkg::OP_SUM, ELEM_TOP, 32'sd1);
    run_pair(are_pkg::OP_MEAN, -32'sd1, -32'sd2);
    send_element(ELEM_BOTTOM);
    send_element(ELEM_BOTTOM);
    run_pair(OP_SPARE6, 32'sd1, 32'sd2);
    run_pair(OP_SPARE7, 32'sd1, 32'sd2);

    // Zero lengths behave as one.
    settle();
    write_reg(are_pkg::REG_OP, are_pkg::CFG_DATA_W'(are_pkg::OP_SUM));
    write_reg(are_pkg::REG_AXIS, '0);
    write_reg(are_pkg::REG_INNER, '0);
    send_element(-32'sd1);
    send_element(32'sd7);

    // A write to the unmapped slot must not restart the tensor.
    settle();
    write_reg(are_pkg::REG_AXIS, 17'd3);
    write_reg(are_pkg::REG_INNER, 17'd1);
    send_element(32'sd10);
    settle();
    write_reg(REG_SPARE, 17'h1ABCD);
    send_element(32'sd20);
    send_element(ELEM_TOP);

    // Oversized inner length: walk the first inner positions back to back.
    settle();
    feed_idle  = 1'b0;
    drain_idle = 1'b0;
    write_reg(are_pkg::REG_OP, are_pkg::CFG_DATA_W'(are_pkg::OP_MIN));
    write_reg(are_pkg::REG_AXIS, 17'd1);
    write_reg(are_pkg::REG_INNER, 17'h007FF);
    repeat (CLAMP_ITEMS) send_element(pick_element());

    // Oversized axis length: a mean that stays open, so no result appears.
    settle();
    write_reg(are_pkg::REG_OP, are_pkg::CFG_DATA_W'(are_pkg::OP_MEAN));
    write_reg(are_pkg::REG_AXIS, 17'h1FFFF);
    write_reg(are_pkg::REG_INNER, 17'd1);
    repeat (CLAMP_ITEMS) send_element(pick_element());

    // Hold the result side off while elements keep coming, so input stalls.
    settle();
    write_reg(are_pkg::REG_OP, are_pkg::CFG_DATA_W'(are_pkg::OP_MAX));
    write_reg(are_pkg::REG_INNER, 17'd4);
    write_reg(are_pkg::REG_AXIS, 17'd1);
    hold_req = 1'b1;
    repeat (40) send_element(pick_element());

    while (random_sent < RANDOM_ITEMS) random_phase();

    settle();
    if (sb.errors == 0) begin
      $display("tb_axis_reduction_engine: PASS");
    end else begin
      $display("tb_axis_reduction_engine: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/are_pkg.sv
rtl/are_in_if.sv
rtl/are_out_if.sv
rtl/are_seq.sv
rtl/are_rmw.sv
rtl/are_div.sv
rtl/axis_reduction_engine.sv
sim/tb_axis_reduction_engine.sv
